// ===== hw/rtl/mtet_pkg.sv =====
// Shared types and constants of the multi-turn encoder tracker.
package mtet_pkg;

  // Operation codes of an input word
  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  // Error codes of a result word
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_MOTOR  = 2'd1,
    ERR_OFFSET = 2'd2
  } err_t;

  // Source of the history field in the output stage
  typedef enum logic [1:0] {
    HIST_ZERO = 2'd0,
    HIST_ONES = 2'd1,
    HIST_RING = 2'd2
  } hist_src_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'd1;

  localparam logic [7:0]  HIGH_THRESHOLD_RST = 8'd192;
  localparam logic [7:0]  LOW_THRESHOLD_RST  = 8'd64;
  localparam logic [15:0] STILL_MAX          = 16'hFFFF;

  typedef struct packed {
    logic       operation;
    logic [7:0] motor_id;
    logic [7:0] raw_position;
    logic [7:0] history_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]         error_code;
    logic signed [31:0] absolute_position;
    logic signed [31:0] velocity;
    logic [15:0]        stopped_count;
    logic signed [31:0] history_position;
  } out_t;

endpackage

// ===== hw/rtl/mtet_state_mem.sv =====
// Per-motor state memory with valid bits and forwarding of the latest write.
module mtet_state_mem import mtet_pkg::*; #(
  parameter int AW = 2,
  parameter int W  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0]     mem [DEPTH];
  logic [W-1:0]     rd_q_r;
  logic [AW-1:0]    rd_addr_r;
  logic [DEPTH-1:0] valid_r;
  logic             wr_valid_r;
  logic [AW-1:0]    wr_addr_r;
  logic [W-1:0]     wr_data_r;

  // Storage, read-before-write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // Entry valid bits and the latest write, kept for forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      wr_valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      wr_valid_r       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wr_addr_r <= wr_addr;
      wr_data_r <= wr_data;
    end
  end

  // Latest write to the entry wins; an entry never written reads as zero
  always_comb begin
    priority if (wr_valid_r && (wr_addr_r == rd_addr_r)) begin
      rd_data = wr_data_r;
    end else if (!valid_r[rd_addr_r]) begin
      rd_data = '0;
    end else begin
      rd_data = rd_q_r;
    end
  end

endmodule

// ===== hw/rtl/mtet_ring_mem.sv =====
// Position history memory, one write and one registered read port.
module mtet_ring_mem import mtet_pkg::*; #(
  parameter int AW = 5,
  parameter int W  = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data_r
);

  logic [W-1:0] mem [2 ** AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/multi_turn_encoder_tracker_top.sv =====
// Multi-turn encoder tracker: top level with the read-modify-write pipeline.
//
// Input words (in_valid/in_ready/in_data) either update a motor with a raw
// wrapping encoder reading or read back a position from its history ring.
// Each input word yields exactly one result word on out_valid/out_ready/
// out_data, in order. The user writes thresholds on cfg_we/cfg_index/
// cfg_wdata only while the block is idle; the block does not enforce this.
//
// The motor state memory is read at acceptance, the update stage then
// updates the state and writes it back (and writes or reads the history
// memory), and the history read data lands with the output register.
// One word is taken every cycle while the receiver does not stall the
// output; the rate is set by the read-modify-write of the state memory,
// whose latest write is forwarded so back-to-back words for the same motor
// see fresh state.
//
// Reset clears all motor state via per-entry valid bits and a per-motor fill
// count for the history ring; no clearing pass is needed. When the receiver
// stalls, the output register holds and one more word waits in the update
// stage before in_ready drops.
module multi_turn_encoder_tracker_top import mtet_pkg::*; #(
  parameter int MOTOR_COUNT   = 4,
  parameter int HISTORY_DEPTH = 8,
  parameter int RAW_BITS      = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  localparam int MB = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int RW = RAW_BITS;
  localparam int PB = POSITION_BITS;

  localparam logic [PB-1:0]   TURN_P   = PB'(64'd1 << RW);
  localparam logic [PB-1:0]   RAW_MASK = PB'((64'd1 << RW) - 64'd1);
  localparam logic [RW+1:0]   TURN_D   = (RW+2)'(1) << RW;
  localparam logic [PW-1:0]   PTR_LAST = PW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0]   CNT_FULL = CW'(HISTORY_DEPTH);

  typedef struct packed {
    logic [RW-1:0] last_raw;
    logic [PB-1:0] pos;
    logic [PB-1:0] vel;
    logic [15:0]   still;
    logic [PW-1:0] ptr;
    logic [CW-1:0] cnt;
  } mst_t;

  // Configuration registers
  logic [7:0] high_thr_r;
  logic [7:0] low_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THRESHOLD_RST;
      low_thr_r  <= LOW_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_THRESHOLD: high_thr_r <= cfg_wdata;
        CFG_LOW_THRESHOLD:  low_thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_r;
  in_t  s1_data_r;
  logic out_valid_r;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= in_data;
    end
  end

  // Motor state memory
  mst_t cur;
  mst_t nxt_st;
  logic st_we;

  mtet_state_mem #(.AW(MB), .W($bits(mst_t))) u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_data.motor_id[MB-1:0]),
    .rd_data (cur),
    .wr_en   (st_we),
    .wr_addr (s1_data_r.motor_id[MB-1:0]),
    .wr_data (nxt_st)
  );

  // Update stage: turn detection, position, velocity, stopped count
  logic                 motor_ok;
  logic                 is_update;
  logic [15:0]          raw16;
  logic [RW-1:0]        raw_m;
  logic [15:0]          prev16;
  logic                 turn_up;
  logic                 turn_dn;
  logic [PB-1:0]        pos_adj;
  logic [PB-1:0]        pos_new;
  logic signed [RW+1:0] delta;
  logic signed [63:0]   delta64;
  logic [PB-1:0]        vel_new;
  logic [15:0]          still_new;
  logic [PW-1:0]        ptr_new;
  logic [CW-1:0]        cnt_new;

  assign motor_ok  = {1'b0, s1_data_r.motor_id} < 9'(MOTOR_COUNT);
  assign is_update = (s1_data_r.operation == OP_UPDATE);
  assign raw16     = 16'(s1_data_r.raw_position);
  assign raw_m     = raw16[RW-1:0];
  assign prev16    = 16'(cur.last_raw);
  assign turn_up   = (prev16 > 16'(high_thr_r)) && (16'(raw_m) < 16'(low_thr_r));
  assign turn_dn   = (prev16 < 16'(low_thr_r)) && (16'(raw_m) > 16'(high_thr_r));

  always_comb begin
    priority if (turn_up && !turn_dn) begin
      pos_adj = cur.pos + TURN_P;
      delta   = $signed({2'b00, raw_m}) - $signed({2'b00, cur.last_raw})
                + $signed(TURN_D);
    end else if (turn_dn && !turn_up) begin
      pos_adj = cur.pos - TURN_P;
      delta   = $signed({2'b00, raw_m}) - $signed({2'b00, cur.last_raw})
                - $signed(TURN_D);
    end else begin
      pos_adj = cur.pos;
      delta   = $signed({2'b00, raw_m}) - $signed({2'b00, cur.last_raw});
    end
  end

  // Low bits of the position always equal the last raw reading
  assign pos_new = (pos_adj & ~RAW_MASK) | PB'(raw_m);
  assign delta64 = 64'(delta);
  assign vel_new = delta64[PB-1:0];

  always_comb begin
    if (vel_new != '0) begin
      still_new = '0;
    end else if (cur.still == STILL_MAX) begin
      still_new = cur.still;
    end else begin
      still_new = cur.still + 16'd1;
    end
  end

  assign ptr_new = (cur.ptr == PTR_LAST) ? '0 : cur.ptr + PW'(1);
  assign cnt_new = (cur.cnt == CNT_FULL) ? cur.cnt : cur.cnt + CW'(1);

  always_comb begin
    nxt_st.last_raw = raw_m;
    nxt_st.pos      = pos_new;
    nxt_st.vel      = vel_new;
    nxt_st.still    = still_new;
    nxt_st.ptr      = ptr_new;
    nxt_st.cnt      = cnt_new;
  end

  assign st_we = s1_adv && is_update && motor_ok;

  // History lookup: slot offset steps back from the write pointer
  logic [8:0]    off9;
  logic          off_ok;
  logic          off_written;
  logic [PW-1:0] off_n;
  logic [PW:0]   idx_full;
  logic [PW-1:0] rd_idx;
  logic          ring_re;

  assign off9        = {1'b0, s1_data_r.history_offset};
  assign off_ok      = off9 < 9'(HISTORY_DEPTH);
  assign off_written = off9 < 9'(cur.cnt);
  assign off_n       = s1_data_r.history_offset[PW-1:0];

  always_comb begin
    if (cur.ptr >= off_n) begin
      idx_full = {1'b0, cur.ptr} - {1'b0, off_n};
    end else begin
      idx_full = {1'b0, cur.ptr} + (PW+1)'(HISTORY_DEPTH) - {1'b0, off_n};
    end
  end

  assign rd_idx  = idx_full[PW-1:0];
  assign ring_re = s1_adv && !is_update && motor_ok && off_ok && off_written;

  logic [PB-1:0] ring_q;

  mtet_ring_mem #(.AW(MB + PW), .W(PB)) u_ring (
    .clk       (clk),
    .wr_en     (st_we),
    .wr_addr   ({s1_data_r.motor_id[MB-1:0], ptr_new}),
    .wr_data   (pos_new),
    .rd_en     (ring_re),
    .rd_addr   ({s1_data_r.motor_id[MB-1:0], rd_idx}),
    .rd_data_r (ring_q)
  );

  // Result fields ahead of the output register
  err_t          res_err;
  logic [PB-1:0] res_pos;
  logic [PB-1:0] res_vel;
  logic [15:0]   res_still;
  hist_src_t     res_src;

  always_comb begin
    res_err   = ERR_NONE;
    res_pos   = cur.pos;
    res_vel   = cur.vel;
    res_still = cur.still;
    res_src   = HIST_ZERO;
    priority if (!motor_ok) begin
      res_err   = ERR_MOTOR;
      res_pos   = '0;
      res_vel   = '0;
      res_still = '0;
      res_src   = HIST_ONES;
    end else if (is_update) begin
      res_pos   = pos_new;
      res_vel   = vel_new;
      res_still = still_new;
    end else if (!off_ok) begin
      res_err = ERR_OFFSET;
      res_src = HIST_ONES;
    end else if (off_written) begin
      res_src = HIST_RING;
    end
  end

  // Output register
  err_t          o_err_r;
  logic [63:0]   o_pos_r;
  logic [63:0]   o_vel_r;
  logic [15:0]   o_still_r;
  hist_src_t     o_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_err_r   <= res_err;
      o_pos_r   <= 64'(res_pos);
      o_vel_r   <= 64'(res_vel);
      o_still_r <= res_still;
      o_src_r   <= res_src;
    end
  end

  logic [63:0] ring_q64;
  logic [31:0] hist_val;

  assign ring_q64 = 64'(ring_q);

  always_comb begin
    unique case (o_src_r)
      HIST_ZERO: hist_val = '0;
      HIST_ONES: hist_val = '1;
      HIST_RING: hist_val = ring_q64[31:0];
      default:   hist_val = '0;
    endcase
  end

  assign out_valid                  = out_valid_r;
  assign out_data.error_code        = o_err_r;
  assign out_data.absolute_position = o_pos_r[31:0];
  assign out_data.velocity          = o_vel_r[31:0];
  assign out_data.stopped_count     = o_still_r;
  assign out_data.history_position  = hist_val;

  // Checks
  ap_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low without a full stalled pipeline");

  ap_write_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (s1_adv && motor_ok))
    else $error("state write without a valid advancing update");

  ap_err_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code != ERR_NONE)) |->
      (out_data.history_position == 32'hFFFF_FFFF))
    else $error("error result without all-ones history");

  ap_motor_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code == ERR_MOTOR)) |->
      ((out_data.absolute_position == 32'sd0) && (out_data.velocity == 32'sd0)
       && (out_data.stopped_count == 16'd0)))
    else $error("bad motor result carries state");

endmodule
